// ===== rtl/core/fuzzy_pd_heading_controller_defines.svh =====
// Assertion macros shared by the heading controller RTL.
`ifndef FUZZY_PD_HEADING_CONTROLLER_DEFINES_SVH
`define FUZZY_PD_HEADING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define FPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define FPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fph_pkg.sv =====
// Types, constants and microcode ROM for the fuzzy PD heading controller.
package fph_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int PC_W       = 4;
    localparam int DIV_BITS   = 21;   // quotient bits; |S| <= 256*L < 2^21
    localparam int CNT_W      = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRV_LIM  = 3'd5;

    // Register reset values
    localparam logic [8:0]  RST_TARGET    = 9'd180;
    localparam logic [3:0]  RST_ERR_GAIN  = 4'd5;
    localparam logic [3:0]  RST_RATE_GAIN = 4'd2;
    localparam logic [9:0]  RST_OUT_GAIN  = 10'd128;
    localparam logic [11:0] RST_LIMIT     = 12'd720;
    localparam logic [6:0]  RST_DRV_LIM   = 7'd50;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_HEAD,
        OP_ERR,
        OP_RATE,
        OP_SE,
        OP_SR,
        OP_ABS,
        OP_CLASS,
        OP_DIVSET,
        OP_DIVSTEP,
        OP_DIVEND,
        OP_OUTER,
        OP_MULOUT,
        OP_MAG,
        OP_OUT
    } t_uop;

    // Sequencer jump conditions
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_WAIT_IN,
        JC_OUTER,
        JC_LOOP,
        JC_OUT_WAIT
    } t_jcond;

    typedef struct packed {
        t_uop              op;
        t_jcond            jc;
        logic [PC_W-1:0]   target;
    } t_uword;

    // Step addresses that are jump targets
    localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] PC_DIVSTEP = 4'd9;
    localparam logic [PC_W-1:0] PC_OUTER   = 4'd11;
    localparam logic [PC_W-1:0] PC_MULOUT  = 4'd12;
    localparam logic [PC_W-1:0] PC_OUT     = 4'd14;

    function automatic t_uword f_urom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{OP_LOAD,    JC_WAIT_IN,  PC_IDLE};
            4'd1:    w = '{OP_HEAD,    JC_NEXT,     PC_IDLE};
            4'd2:    w = '{OP_ERR,     JC_NEXT,     PC_IDLE};
            4'd3:    w = '{OP_RATE,    JC_NEXT,     PC_IDLE};
            4'd4:    w = '{OP_SE,      JC_NEXT,     PC_IDLE};
            4'd5:    w = '{OP_SR,      JC_NEXT,     PC_IDLE};
            4'd6:    w = '{OP_ABS,     JC_NEXT,     PC_IDLE};
            4'd7:    w = '{OP_CLASS,   JC_OUTER,    PC_OUTER};
            4'd8:    w = '{OP_DIVSET,  JC_NEXT,     PC_IDLE};
            4'd9:    w = '{OP_DIVSTEP, JC_LOOP,     PC_DIVSTEP};
            4'd10:   w = '{OP_DIVEND,  JC_ALWAYS,   PC_MULOUT};
            4'd11:   w = '{OP_OUTER,   JC_NEXT,     PC_IDLE};
            4'd12:   w = '{OP_MULOUT,  JC_NEXT,     PC_IDLE};
            4'd13:   w = '{OP_MAG,     JC_NEXT,     PC_IDLE};
            4'd14:   w = '{OP_OUT,     JC_OUT_WAIT, PC_IDLE};
            default: w = '{OP_NOP,     JC_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/fuzzy_pd_heading_controller.sv =====
// Fuzzy PD heading controller: microcoded sequencer, shared multiplier, serial divider.
// The outer and corner regions skip the divider; the inner region runs a 21-step
//   restoring divider loop. A new compass beat is taken only once the sequencer is back in idle,
//   and an output stall holds the sequencer in its output step.
// Reset (i_rst_n low, synchronous): registers to defaults, previous error and wheel holds
//   to zero, sequencer to idle, output empty. No clearing pass.
`include "fuzzy_pd_heading_controller_defines.svh"

module fuzzy_pd_heading_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fph_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // compass sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [9:0]              i_compass_raw,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [8:0]                     o_heading_deg,
    output logic signed [8:0]              o_heading_error,
    output logic [6:0]                     o_drive_magnitude,
    output logic signed [7:0]              o_right_drive,
    output logic signed [7:0]              o_left_drive
);
    import fph_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0]  r_target;
    logic [3:0]  r_eg;
    logic [3:0]  r_rg;
    logic [9:0]  r_og;
    logic [11:0] r_lim;
    logic [6:0]  r_dlim;

    // Controller state
    logic signed [8:0] r_prev;
    logic signed [7:0] r_right_hold;
    logic signed [7:0] r_left_hold;

    // Sequencer
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_uw;
    logic            r_out_valid;

    // Datapath work registers
    logic signed [9:0]  r_rd;       // reading after negative fix-up
    logic [8:0]         r_heading;
    logic signed [8:0]  r_err;
    logic signed [9:0]  r_rate;
    logic signed [12:0] r_se;       // scaled error E
    logic signed [13:0] r_sr;       // scaled rate R
    logic [12:0]        r_ae;
    logic [13:0]        r_ar;
    logic               r_e_in;     // |E| <= L
    logic               r_r_in;     // |R| <= L
    logic signed [14:0] r_esum;     // E + R
    logic [12:0]        r_den;      // 2L - max(|E|,|R|)
    logic [31:0]        r_rem;      // divider remainder, starts |L*(E+R)|*128
    logic [32:0]        r_dsh;      // divisor, shifted down one place per step
    logic [DIV_BITS-1:0] r_quo;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [21:0] r_s;        // surface value, Q8
    logic signed [36:0] r_prod;     // shared multiplier output
    logic [6:0]         r_mag;

    // Output payload
    logic [8:0]        r_o_heading;
    logic signed [8:0] r_o_error;
    logic [6:0]        r_o_mag;

    logic w_in_accept;
    logic w_out_free;
    logic w_load_out;

    assign w_uw        = f_urom(r_pc);
    assign o_in_stall  = (r_pc != PC_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Result register may be refilled once its beat has gone or in the same cycle.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = (w_uw.op == OP_OUT) && w_out_free;

    // ------------------------------------------------------------------
    // Step counter and jumps
    // ------------------------------------------------------------------
    always_comb begin
        case (w_uw.jc)
            JC_NEXT:     n_pc = r_pc + 1'b1;
            JC_ALWAYS:   n_pc = w_uw.target;
            JC_WAIT_IN:  n_pc = w_in_accept ? r_pc + 1'b1 : r_pc;
            JC_OUTER:    n_pc = (r_e_in && r_r_in) ? r_pc + 1'b1 : w_uw.target;
            JC_LOOP:     n_pc = (r_cnt != '0) ? w_uw.target : r_pc + 1'b1;
            JC_OUT_WAIT: n_pc = w_out_free ? w_uw.target : r_pc;
            default:     n_pc = PC_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operands picked by the micro-op, product registered
    // ------------------------------------------------------------------
    logic signed [21:0] w_mul_a;
    logic signed [14:0] w_mul_b;
    logic               w_mul_en;

    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        case (w_uw.op)
            OP_RATE: begin      // E = err * error_gain
                w_mul_a = $signed({{13{r_err[8]}}, r_err});
                w_mul_b = $signed({11'b0, r_eg});
            end
            OP_SE: begin        // R = rate * rate_gain
                w_mul_a = $signed({{12{r_rate[9]}}, r_rate});
                w_mul_b = $signed({11'b0, r_rg});
            end
            OP_CLASS: begin     // L * (E + R)
                w_mul_a = $signed({10'b0, r_lim});
                w_mul_b = r_esum;
            end
            OP_MULOUT: begin    // S * output gain
                w_mul_a = r_s;
                w_mul_b = $signed({5'b0, r_og});
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath combinational pieces
    // ------------------------------------------------------------------
    logic signed [10:0] w_v;
    logic signed [10:0] w_v_lo;
    logic signed [10:0] w_v_hi;
    logic [8:0]         w_tmod;
    logic signed [9:0]  w_d;
    logic signed [9:0]  w_rate;
    logic [13:0]        w_m;
    logic [13:0]        w_den;
    logic [36:0]        w_absprod;
    logic               w_ge;
    logic [31:0]        w_sub;
    logic [DIV_BITS-1:0] w_q16;
    logic signed [14:0] w_l15;
    logic signed [14:0] w_se15;
    logic signed [14:0] w_sr15;
    logic signed [14:0] w_base;
    logic signed [21:0] w_outer;
    logic               w_e_pos;
    logic               w_e_neg;
    logic               w_r_pos;
    logic               w_r_neg;
    logic [7:0]         w_mag8;
    logic [7:0]         w_magn8;

    assign w_v    = 11'sd360 - $signed({r_rd[9], r_rd});
    assign w_v_lo = w_v + 11'sd360;
    assign w_v_hi = w_v - 11'sd360;

    assign w_tmod = (r_target >= 9'd360) ? r_target - 9'd360 : r_target;
    assign w_d    = $signed({1'b0, w_tmod}) - $signed({1'b0, r_heading});
    assign w_rate = $signed({r_err[8], r_err}) - $signed({r_prev[8], r_prev});

    assign w_m   = ({1'b0, r_ae} >= r_ar) ? {1'b0, r_ae} : r_ar;
    assign w_den = {1'b0, r_lim, 1'b0} - w_m;

    assign w_absprod = r_prod[36] ? 37'(-r_prod) : 37'(r_prod);
    assign w_ge      = ({1'b0, r_rem} >= r_dsh);
    assign w_sub     = r_rem - r_dsh[31:0];
    assign w_q16     = w_absprod[36:16];

    // Outer and corner rules
    assign w_l15   = $signed({3'b0, r_lim});
    assign w_se15  = $signed({{2{r_se[12]}}, r_se});
    assign w_sr15  = $signed({r_sr[13], r_sr});
    assign w_e_pos = !r_e_in && !r_se[12];
    assign w_e_neg = !r_e_in &&  r_se[12];
    assign w_r_pos = !r_r_in && !r_sr[13];
    assign w_r_neg = !r_r_in &&  r_sr[13];

    always_comb begin
        w_base  = '0;
        w_outer = '0;
        if (w_e_pos && r_r_in) begin
            w_base  = w_l15 + w_sr15;
            w_outer = $signed({{7{w_base[14]}}, w_base}) <<< 7;
        end else if (w_r_pos && r_e_in) begin
            w_base  = w_l15 + w_se15;
            w_outer = $signed({{7{w_base[14]}}, w_base}) <<< 7;
        end else if (w_e_neg && r_r_in) begin
            w_base  = w_sr15 - w_l15;
            w_outer = $signed({{7{w_base[14]}}, w_base}) <<< 7;
        end else if (w_r_neg && r_e_in) begin
            w_base  = w_se15 - w_l15;
            w_outer = $signed({{7{w_base[14]}}, w_base}) <<< 7;
        end else if (w_e_pos && w_r_pos) begin
            w_outer = $signed({2'b0, r_lim, 8'b0});
        end else if (w_e_neg && w_r_neg) begin
            w_outer = -$signed({2'b0, r_lim, 8'b0});
        end
    end

    assign w_mag8  = {1'b0, r_mag};
    assign w_magn8 = 8'd0 - w_mag8;

    // ------------------------------------------------------------------
    // Control registers: sequencer, configuration, controller state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_IDLE;
            r_out_valid  <= 1'b0;
            r_target     <= RST_TARGET;
            r_eg         <= RST_ERR_GAIN;
            r_rg         <= RST_RATE_GAIN;
            r_og         <= RST_OUT_GAIN;
            r_lim        <= RST_LIMIT;
            r_dlim       <= RST_DRV_LIM;
            r_prev       <= '0;
            r_right_hold <= '0;
            r_left_hold  <= '0;
        end else begin
            r_pc <= n_pc;

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET:    r_target <= i_cfg_data[8:0];
                    CFG_ERR_GAIN:  r_eg     <= i_cfg_data[3:0];
                    CFG_RATE_GAIN: r_rg     <= i_cfg_data[3:0];
                    CFG_OUT_GAIN:  r_og     <= i_cfg_data[9:0];
                    CFG_LIMIT:     r_lim    <= i_cfg_data[11:0];
                    CFG_DRV_LIM:   r_dlim   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (w_uw.op == OP_RATE) begin
                r_prev <= r_err;
            end

            // zero scaled error keeps the last wheel drives
            if (w_load_out && (r_se != '0)) begin
                if (!r_se[12]) begin
                    r_right_hold <= $signed(w_mag8);
                    r_left_hold  <= $signed(w_magn8);
                end else begin
                    r_right_hold <= $signed(w_magn8);
                    r_left_hold  <= $signed(w_mag8);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end

        case (w_uw.op)
            OP_LOAD: begin
                if (w_in_accept) begin
                    r_rd <= i_compass_raw[9] ? i_compass_raw + 10'sd256 : i_compass_raw;
                end
            end
            OP_HEAD: begin
                if (w_v < 0) begin
                    r_heading <= w_v_lo[8:0];
                end else if (w_v >= 11'sd360) begin
                    r_heading <= w_v_hi[8:0];
                end else begin
                    r_heading <= w_v[8:0];
                end
            end
            OP_ERR: begin
                if (w_d > 10'sd180) begin
                    r_err <= 9'(w_d - 10'sd360);
                end else if (w_d < -10'sd180) begin
                    r_err <= 9'(w_d + 10'sd360);
                end else begin
                    r_err <= w_d[8:0];
                end
            end
            OP_RATE: begin
                r_rate <= w_rate;
            end
            OP_SE: begin
                r_se <= r_prod[12:0];
            end
            OP_SR: begin
                r_sr <= r_prod[13:0];
            end
            OP_ABS: begin
                r_ae   <= r_se[12] ? 13'(-r_se) : 13'(r_se);
                r_ar   <= r_sr[13] ? 14'(-r_sr) : 14'(r_sr);
                r_e_in <= ((r_se[12] ? 13'(-r_se) : 13'(r_se)) <= {1'b0, r_lim});
                r_r_in <= ((r_sr[13] ? 14'(-r_sr) : 14'(r_sr)) <= {2'b0, r_lim});
                r_esum <= $signed({{2{r_se[12]}}, r_se}) + $signed({r_sr[13], r_sr});
            end
            OP_CLASS: begin
                r_den <= w_den[12:0];
            end
            OP_DIVSET: begin
                // trunc(L(E+R)*256 / 2d) == trunc(L(E+R)*128 / d)
                r_rem <= {w_absprod[24:0], 7'b0};
                r_neg <= r_prod[36];
                r_dsh <= {r_den, 20'b0};
                r_quo <= '0;
                r_cnt <= CNT_W'(DIV_BITS - 1);
            end
            OP_DIVSTEP: begin
                if (w_ge) begin
                    r_rem <= w_sub;
                end
                r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_DIVEND: begin
                // zero divisor only with L = 0 and E = R = 0
                if (r_den == '0) begin
                    r_s <= '0;
                end else if (r_neg) begin
                    r_s <= -$signed({1'b0, r_quo});
                end else begin
                    r_s <= $signed({1'b0, r_quo});
                end
            end
            OP_OUTER: begin
                r_s <= w_outer;
            end
            OP_MAG: begin
                r_mag <= (w_q16 > {14'b0, r_dlim}) ? r_dlim : w_q16[6:0];
            end
            OP_OUT: begin
                if (w_load_out) begin
                    r_o_heading <= r_heading;
                    r_o_error   <= r_err;
                    r_o_mag     <= r_mag;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_heading_deg     = r_o_heading;
    assign o_heading_error   = r_o_error;
    assign o_drive_magnitude = r_o_mag;
    assign o_right_drive     = r_right_hold;
    assign o_left_drive      = r_left_hold;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FPH_ASSERT_NOW(a_wheels_opposite, o_out_valid, o_left_drive == 8'(-o_right_drive), "left drive is not the negative of right drive")
    `FPH_ASSERT_NOW(a_idle_from_out, $past(i_rst_n) && (r_pc == PC_IDLE) && ($past(r_pc) != PC_IDLE), $past(r_pc) == PC_OUT, "sequencer returned to idle from a step other than output")
    `FPH_ASSERT_NOW(a_valid_from_out, $past(i_rst_n) && $rose(r_out_valid), $past(r_pc) == PC_OUT, "result valid rose without an output step")
    `FPH_ASSERT_NEXT(a_out_step_loads, (r_pc == PC_OUT) && w_out_free, (r_pc == PC_IDLE) && r_out_valid, "output step did not load the result and return to idle")

endmodule

// ===== test/fuzzy_pd_heading_controller_checker.sv =====
// Checker for the fuzzy PD heading controller: predicts every result and compares beats.
module fuzzy_pd_heading_controller_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [fph_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic signed [9:0]              i_compass_raw,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [8:0]                     i_heading_deg,
    input  logic signed [8:0]              i_heading_error,
    input  logic [6:0]                     i_drive_magnitude,
    input  logic signed [7:0]              i_right_drive,
    input  logic signed [7:0]              i_left_drive,
    output int                             o_fail_count,
    output int                             o_outstanding,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import fph_pkg::*;

    typedef struct packed {
        logic [8:0]        heading_deg;
        logic signed [8:0] heading_error;
        logic [6:0]        drive_magnitude;
        logic signed [7:0] right_drive;
        logic signed [7:0] left_drive;
    } t_steer;

    // register shadows
    logic [8:0]  target_q;
    logic [3:0]  err_gain_q;
    logic [3:0]  rate_gain_q;
    logic [9:0]  out_gain_q;
    logic [11:0] limit_q;
    logic [6:0]  drv_lim_q;

    // controller memory
    logic signed [8:0] last_error;
    logic signed [7:0] right_held;
    logic signed [7:0] left_held;

    t_steer steering_due [$];

    int fail_count = 0;
    int outstanding = 0;
    int checked = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;
    assign o_checked     = checked;

    // Analytical fuzzy PD surface, Q8, division truncating toward zero.
    function automatic longint fuzzy_surface(input longint e, input longint r, input longint lim);
        longint ae;
        longint ar;
        longint m;
        longint den;
        ae = (e < 0) ? -e : e;
        ar = (r < 0) ? -r : r;
        if (ae <= lim && ar <= lim) begin
            m   = (ae >= ar) ? ae : ar;
            den = 2 * (2 * lim - m);
            if (den <= 0) return 0;
            return (lim * (e + r) * 256) / den;
        end
        if (e > lim && ar <= lim)  return (lim + r) * 128;
        if (r > lim && ae <= lim)  return (lim + e) * 128;
        if (e < -lim && ar <= lim) return (-lim + r) * 128;
        if (r < -lim && ae <= lim) return (-lim + e) * 128;
        if (e > lim && r > lim)    return lim * 256;
        if (e < -lim && r < -lim)  return -lim * 256;
        return 0;
    endfunction

    task automatic predict_steering(input logic signed [9:0] raw);
        longint reading;
        longint hdg;
        longint tgt;
        longint err;
        longint rate;
        longint eg;
        longint rg;
        longint og;
        longint lim;
        longint dl;
        longint se;
        longint sr;
        longint s;
        longint p;
        longint mag;
        longint neg;
        t_steer res;
        reading = raw;
        if (reading < 0) reading += 256;
        hdg = (360 - reading) % 360;
        if (hdg < 0) hdg += 360;
        tgt = target_q;
        tgt = tgt % 360;
        err = tgt - hdg;
        if (err > 180)  err -= 360;
        if (err < -180) err += 360;
        rate = err - last_error;
        last_error = err[8:0];
        eg  = err_gain_q;
        rg  = rate_gain_q;
        og  = out_gain_q;
        lim = limit_q;
        dl  = drv_lim_q;
        se  = err * eg;
        sr  = rate * rg;
        s   = fuzzy_surface(se, sr, lim);
        p   = s * og;
        mag = ((p < 0) ? -p : p) >> 16;
        if (mag > dl) mag = dl;
        neg = -mag;
        // zero scaled error keeps the last wheel commands
        if (se > 0) begin
            right_held = mag[7:0];
            left_held  = neg[7:0];
        end else if (se < 0) begin
            right_held = neg[7:0];
            left_held  = mag[7:0];
        end
        res.heading_deg     = hdg[8:0];
        res.heading_error   = err[8:0];
        res.drive_magnitude = mag[6:0];
        res.right_drive     = right_held;
        res.left_drive      = left_held;
        steering_due.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_steer due;
        if (!i_rst_n) begin
            target_q    = RST_TARGET;
            err_gain_q  = RST_ERR_GAIN;
            rate_gain_q = RST_RATE_GAIN;
            out_gain_q  = RST_OUT_GAIN;
            limit_q     = RST_LIMIT;
            drv_lim_q   = RST_DRV_LIM;
            last_error  = '0;
            right_held  = '0;
            left_held   = '0;
            steering_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET:    target_q    = i_cfg_data[8:0];
                    CFG_ERR_GAIN:  err_gain_q  = i_cfg_data[3:0];
                    CFG_RATE_GAIN: rate_gain_q = i_cfg_data[3:0];
                    CFG_OUT_GAIN:  out_gain_q  = i_cfg_data[9:0];
                    CFG_LIMIT:     limit_q     = i_cfg_data[11:0];
                    CFG_DRV_LIM:   drv_lim_q   = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            // result beat belongs to an older sample, so retire it first
            if (i_out_valid && !i_out_stall) begin
                if (steering_due.size() == 0) begin
                    $error("result beat with no sample outstanding");
                    fail_count++;
                end else begin
                    due = steering_due.pop_front();
                    checked++;
                    if (i_heading_deg !== due.heading_deg) begin
                        $error("heading_deg: expected %0d, got %0d",
                               due.heading_deg, i_heading_deg);
                        fail_count++;
                    end
                    if (i_heading_error !== due.heading_error) begin
                        $error("heading_error: expected %0d, got %0d",
                               due.heading_error, i_heading_error);
                        fail_count++;
                    end
                    if (i_drive_magnitude !== due.drive_magnitude) begin
                        $error("drive_magnitude: expected %0d, got %0d",
                               due.drive_magnitude, i_drive_magnitude);
                        fail_count++;
                    end
                    if (i_right_drive !== due.right_drive) begin
                        $error("right_drive: expected %0d, got %0d",
                               due.right_drive, i_right_drive);
                        fail_count++;
                    end
                    if (i_left_drive !== due.left_drive) begin
                        $error("left_drive: expected %0d, got %0d",
                               due.left_drive, i_left_drive);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_steering(i_compass_raw);
        end
        outstanding = steering_due.size();
    end

endmodule

// ===== test/fuzzy_pd_heading_controller_tb.sv =====
// Top of the heading controller testbench: clock, reset, stimulus and verdict.
module fuzzy_pd_heading_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fph_pkg::*;

    // indexes past the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int SAMPLE_TOTAL = 1550;   // directed beats plus the random run
    localparam int DRAIN_CYCLES = 40;     // a little over the inner-region latency

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic signed [9:0]     compass_raw  = '0;
    logic                  out_stall    = 1'b0;

    logic                  cfg_ready;
    logic                  in_stall;
    logic                  out_valid;
    logic [8:0]            heading_deg;
    logic signed [8:0]     heading_error;
    logic [6:0]            drive_magnitude;
    logic signed [7:0]     right_drive;
    logic signed [7:0]     left_drive;

    int fail_count;
    int outstanding;
    int checked;

    int  sent       = 0;
    int  settings   = 0;
    int  cur_target = 180;   // target mod 360, for aiming samples at zero error
    bit  calm       = 1'b0;  // no idling on either side while set

    fuzzy_pd_heading_controller u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_compass_raw     (compass_raw),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_heading_deg     (heading_deg),
        .o_heading_error   (heading_error),
        .o_drive_magnitude (drive_magnitude),
        .o_right_drive     (right_drive),
        .o_left_drive      (left_drive)
    );

    fuzzy_pd_heading_controller_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_compass_raw     (compass_raw),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_heading_deg     (heading_deg),
        .i_heading_error   (heading_error),
        .i_drive_magnitude (drive_magnitude),
        .i_right_drive     (right_drive),
        .i_left_drive      (left_drive),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_checked         (checked)
    );

    // 10 ns clock; stimulus moves on falling edges, the checker samples on rising ones
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Value for a register field, with random junk above the field when messy.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int value, input int width,
                                                        input bit messy);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] junk;
        keep = CFG_DATA_W'((1 << width) - 1);
        junk = messy ? CFG_DATA_W'($urandom) : '0;
        return (junk & ~keep) | (CFG_DATA_W'(value) & keep);
    endfunction

    // Mostly uniform, with the two ends of the range weighted up.
    function automatic int pick(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // One register beat; valid stays high across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Lower sample valid and wait until every predicted result has been taken.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    // Full register setting, written only once the block has drained.
    task automatic configure(input int tgt, input int eg, input int rg, input int og,
                             input int lim, input int dl, input bit messy, input bit spare);
        wait_idle();
        if (spare) write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_TARGET,    with_junk(tgt, 9, messy));
        write_reg(CFG_ERR_GAIN,  with_junk(eg, 4, messy));
        write_reg(CFG_RATE_GAIN, with_junk(rg, 4, messy));
        write_reg(CFG_OUT_GAIN,  with_junk(og, 10, messy));
        write_reg(CFG_LIMIT,     with_junk(lim, 12, messy));
        write_reg(CFG_DRV_LIM,   with_junk(dl, 7, messy));
        if (spare) write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        @(negedge clk);
        cur_target = (tgt % 512) % 360;
        settings++;
    endtask

    // One compass beat after a random gap; with no gap valid simply stays high.
    task automatic send_sample(input int raw);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        compass_raw <= 10'(raw);
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    // Result side: stall for a random number of cycles, then take one beat.
    initial begin : result_backpressure
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 9);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int walk;
        int raw;
        int n;
        walk = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: target 180, outer region reachable through the error alone.
        send_sample(180);    // heading on target: scaled error zero, holds at reset value
        send_sample(0);      // heading 0, error +180
        send_sample(-128);   // negative reading, folded by +256
        send_sample(-1);
        send_sample(359);    // error +179
        send_sample(1);      // error -179
        send_sample(90);
        send_sample(270);
        send_sample(181);
        send_sample(179);
        send_sample(360);    // readings past the range still give a heading in 0..359
        send_sample(511);
        send_sample(-512);

        // Target past 359, full gains, tiny limit: corners in both directions.
        configure(511, 15, 15, 1023, 1, 127, 1'b1, 1'b0);
        send_sample(209);    // heading 151 = 511 mod 360, hold with drive limit over 100
        send_sample(0);
        send_sample(100);
        send_sample(300);
        send_sample(-100);
        send_sample(31);     // large negative error after a smaller negative one: both below -L

        // Limit of zero: only a zero pair stays inside, where the surface is zero.
        configure(0, 1, 1, 1023, 0, 100, 1'b0, 1'b0);
        send_sample(0);
        send_sample(0);
        send_sample(10);
        send_sample(350);

        // Zero error gain keeps the wheels held; spare indexes must change nothing.
        configure(359, 0, 15, 512, 4095, 100, 1'b0, 1'b1);
        send_sample(1);
        send_sample(200);
        send_sample(-50);

        // Random settings, each followed by a run of samples.
        while (sent < SAMPLE_TOTAL) begin
            configure(pick(0, 511), pick(0, 15), pick(0, 15), pick(0, 1023),
                      pick(0, 4095), pick(0, 127), $urandom_range(0, 1),
                      $urandom_range(0, 3) == 0);
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(30, 120);
            if (n > SAMPLE_TOTAL - sent) n = SAMPLE_TOTAL - sent;
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        // slowly turning compass, as a real vehicle gives
                        walk = walk + $urandom_range(0, 20) - 10;
                        if (walk > 359) walk -= 360;
                        if (walk < 0)   walk += 360;
                        raw = walk;
                    end
                    6: begin
                        // reading that puts the heading exactly on target
                        walk = (360 - cur_target) % 360;
                        raw  = walk;
                    end
                    7, 8:    raw = $urandom_range(359 + 128, 0) - 128;
                    default: raw = $urandom_range(1023, 0) - 512;   // any 10-bit code
                endcase
                // readings 128..255 may also arrive in their negative form
                if (raw >= 128 && raw <= 255 && $urandom_range(0, 1) == 1) raw -= 256;
                send_sample(raw);
            end
            calm = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d compass samples over %0d register settings (reset one included)",
                 sent, settings + 1);
        $display("Checked %0d result beats; gaps, stalls and extreme settings all exercised",
                 checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard: several times the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fph_pkg.sv
rtl/core/fuzzy_pd_heading_controller.sv
test/fuzzy_pd_heading_controller_checker.sv
test/fuzzy_pd_heading_controller_tb.sv
